/* rtl/kvp_pkg.sv */
// Package with the shared types, character codes and helpers of the request parser.
`default_nettype none
package kvp_pkg;

    // Parser phases.
    typedef enum logic [4:0] {
        PH_IDLE, PH_HEADER, PH_CMD_SKIP, PH_CMD, PH_KEY_SKIP, PH_KEY,
        PH_FLAGS_SKIP, PH_FLAGS, PH_EXP_SKIP, PH_EXP, PH_BYTES_SKIP, PH_BYTES,
        PH_EOL_SKIP, PH_EOL_LF, PH_VALUE, PH_VEOL, PH_VEOL_LF, PH_DRAIN
    } t_phase;

    typedef enum logic [1:0] {
        OUTC_PENDING, OUTC_OK, OUTC_FAIL
    } t_outcome;

    typedef enum logic [1:0] {
        KIND_HEADER, KIND_KEY, KIND_VALUE, KIND_VERDICT
    } t_kind;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_LISTEN_PORT   = 2'd0;
    localparam logic [1:0] REG_MAX_KEY_LEN   = 2'd1;
    localparam logic [1:0] REG_MAX_VALUE_LEN = 2'd2;

    // Character codes.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0b;
    localparam logic [7:0] CH_FF    = 8'h0c;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5a;
    localparam logic [7:0] CH_LO_G  = 8'h67;
    localparam logic [7:0] CH_LO_S  = 8'h73;
    localparam logic [7:0] CH_LO_E  = 8'h65;
    localparam logic [7:0] CH_LO_T  = 8'h74;

    // Number accumulator saturation point, 2^32.
    localparam logic [32:0] NUM_SAT = 33'h1_0000_0000;

    // Number mark bits.
    localparam int MARK_SIGN  = 0;
    localparam int MARK_MINUS = 1;
    localparam int MARK_DIGIT = 2;

    // One result item.
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic        verdict_ok;
        logic        cmd_is_set;
        logic [7:0]  key_len;
        logic [31:0] item_flags;
        logic [31:0] expire_time;
        logic [20:0] value_bytes;
        logic        end_of_run;
    } t_result;

    // Number token state after one character.
    typedef struct packed {
        logic [4:0]  tok;
        logic [32:0] acc;
        logic [2:0]  marks;
        logic        bad;
    } t_num;

    // Adds one character to a decimal number token.
    function automatic t_num f_num_char(input logic [7:0] b, input logic [4:0] tok,
                                        input logic [32:0] acc, input logic [2:0] marks);
        t_num        n;
        logic [36:0] wide;
        logic [7:0]  dig;
        n.tok   = (tok < 5'd31) ? tok + 5'd1 : tok;
        n.acc   = acc;
        n.marks = marks;
        n.bad   = 1'b0;
        dig     = b - CH_ZERO;
        wide    = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {33'b0, dig[3:0]};
        if (b >= CH_ZERO && b <= CH_NINE) begin
            n.acc = (wide > {4'b0, NUM_SAT}) ? NUM_SAT : wide[32:0];
            n.marks[MARK_DIGIT] = 1'b1;
        end else if ((b == CH_PLUS || b == CH_MINUS) && marks == 3'b000) begin
            n.marks = (b == CH_MINUS) ? 3'b011 : 3'b001;
        end else if ((b == CH_TAB || b == CH_VT || b == CH_FF) && marks == 3'b000) begin
            n.bad = 1'b0;
        end else begin
            n.bad = 1'b1;
        end
        return n;
    endfunction

endpackage
`default_nettype wire

/* rtl/kvp_if.sv */
// Stream interfaces for the input byte channel and the result channel.
`default_nettype none
interface kvp_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  pkt_byte;
    logic        first_byte;
    logic        last_byte;
    logic        is_udp;
    logic [15:0] dst_port;

    modport source (output valid, pkt_byte, first_byte, last_byte, is_udp, dst_port,
                    input ready);
    modport sink   (input valid, pkt_byte, first_byte, last_byte, is_udp, dst_port,
                    output ready);
endinterface

interface kvp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  out_kind;
    logic [7:0]  out_byte;
    logic        verdict_ok;
    logic        cmd_is_set;
    logic [7:0]  key_len;
    logic [31:0] item_flags;
    logic [31:0] expire_time;
    logic [20:0] value_bytes;
    logic        end_of_run;

    modport source (output valid, out_kind, out_byte, verdict_ok, cmd_is_set, key_len,
                    item_flags, expire_time, value_bytes, end_of_run, input ready);
    modport sink   (input valid, out_kind, out_byte, verdict_ok, cmd_is_set, key_len,
                    item_flags, expire_time, value_bytes, end_of_run, output ready);
endinterface
`default_nettype wire

/* rtl/kvp_parser.sv */
// Per-byte parser state machine that turns one payload byte into up to two results.
`default_nettype none
module kvp_parser
    import kvp_pkg::*;
#(
    parameter int HEADER_BYTES     = 8,
    parameter int NUMBER_TOKEN_MAX = 15
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire logic [7:0]  i_pkt_byte,
    input  wire logic        i_first_byte,
    input  wire logic        i_last_byte,
    input  wire logic        i_is_udp,
    input  wire logic [15:0] i_dst_port,
    input  wire logic [15:0] i_listen_port,
    input  wire logic [7:0]  i_max_key_len,
    input  wire logic [20:0] i_max_value_len,
    output t_result          o_res0,
    output t_result          o_res1,
    output logic [1:0]       o_push_cnt
);

    localparam logic [4:0] HDR_LIMIT = 5'(HEADER_BYTES);
    localparam logic [4:0] TOK_LIMIT = 5'(NUMBER_TOKEN_MAX);

    t_phase      r_phase, n_phase;
    t_outcome    r_outcome, n_outcome;
    logic [3:0]  r_hdr_cnt, n_hdr_cnt;
    logic [4:0]  r_tok_cnt, n_tok_cnt;
    logic [1:0]  r_cmd, n_cmd;
    logic [7:0]  r_key_cnt, n_key_cnt;
    logic [32:0] r_acc, n_acc;
    logic [2:0]  r_marks, n_marks;
    logic [31:0] r_flags, n_flags;
    logic [31:0] r_expiry, n_expiry;
    logic [20:0] r_vcount, n_vcount;
    logic [20:0] r_vrem, n_vrem;

    // Line end handling after the last token of the command line.
    function automatic void f_eol(input logic [7:0] b, input logic [1:0] cm,
                                  input logic [20:0] vrem, inout t_phase ph,
                                  inout t_outcome oc);
        if (b == CH_SPACE) begin
            ph = ph;
        end else if (b == CH_CR) begin
            ph = PH_EOL_LF;
        end else if (b == CH_LF) begin
            if (cm != 2'b10) begin
                ph = PH_DRAIN;
                oc = OUTC_OK;
            end else begin
                ph = (vrem != 21'd0) ? PH_VALUE : PH_VEOL;
            end
        end else begin
            ph = PH_DRAIN;
            oc = OUTC_FAIL;
        end
    endfunction

    // Next state and the results of one accepted byte.
    always_comb begin
        logic        is_sp;
        logic        is_dl;
        logic        go;
        logic [7:0]  lo;
        logic [1:0]  kind_byte;
        logic        has_byte;
        logic        num_ok;
        t_num        nc;
        t_result     rb;
        t_result     rv;
        n_phase   = r_phase;
        n_outcome = r_outcome;
        n_hdr_cnt = r_hdr_cnt;
        n_tok_cnt = r_tok_cnt;
        n_cmd     = r_cmd;
        n_key_cnt = r_key_cnt;
        n_acc     = r_acc;
        n_marks   = r_marks;
        n_flags   = r_flags;
        n_expiry  = r_expiry;
        n_vcount  = r_vcount;
        n_vrem    = r_vrem;
        is_sp     = (i_pkt_byte == CH_SPACE);
        is_dl     = is_sp || i_pkt_byte == CH_CR || i_pkt_byte == CH_LF;
        go        = 1'b0;
        lo        = (i_pkt_byte >= CH_UP_A && i_pkt_byte <= CH_UP_Z) ?
                    i_pkt_byte + 8'd32 : i_pkt_byte;
        kind_byte = KIND_HEADER;
        has_byte  = 1'b0;
        num_ok    = 1'b0;
        nc        = '0;
        o_push_cnt = 2'd0;

        // Packet start clears the request state.
        if (i_first_byte) begin
            n_hdr_cnt = '0;
            n_tok_cnt = '0;
            n_cmd     = 2'b11;
            n_key_cnt = '0;
            n_acc     = '0;
            n_marks   = '0;
            n_flags   = '0;
            n_expiry  = '0;
            n_vcount  = '0;
            n_vrem    = '0;
            n_outcome = OUTC_PENDING;
            if (!i_is_udp || i_dst_port != i_listen_port) begin
                n_phase   = PH_DRAIN;
                n_outcome = OUTC_FAIL;
            end else begin
                n_phase = (HEADER_BYTES > 0) ? PH_HEADER : PH_CMD_SKIP;
            end
        end

        if (n_phase == PH_HEADER) begin
            has_byte  = 1'b1;
            kind_byte = KIND_HEADER;
            n_hdr_cnt = n_hdr_cnt + 4'd1;
            if ({1'b0, n_hdr_cnt} >= HDR_LIMIT) begin
                n_phase = PH_CMD_SKIP;
            end
        end else begin
            case (n_phase)
                PH_CMD_SKIP, PH_CMD: begin
                    go = 1'b1;
                    if (n_phase == PH_CMD_SKIP) begin
                        if (is_sp) begin
                            go = 1'b0;
                        end else if (is_dl) begin
                            go = 1'b0;
                            n_phase = PH_DRAIN;
                            n_outcome = OUTC_FAIL;
                        end else begin
                            n_tok_cnt = '0;
                            n_cmd = 2'b11;
                            n_phase = PH_CMD;
                        end
                    end
                    if (go) begin
                        if (is_dl) begin
                            if (is_sp && n_tok_cnt == 5'd3 && n_cmd != 2'b00) begin
                                n_phase = PH_KEY_SKIP;
                            end else begin
                                n_phase = PH_DRAIN;
                                n_outcome = OUTC_FAIL;
                            end
                        end else begin
                            if (n_tok_cnt == 5'd0) begin
                                if (lo != CH_LO_G) n_cmd[0] = 1'b0;
                                if (lo != CH_LO_S) n_cmd[1] = 1'b0;
                            end else if (n_tok_cnt == 5'd1) begin
                                if (lo != CH_LO_E) n_cmd = 2'b00;
                            end else if (n_tok_cnt == 5'd2) begin
                                if (lo != CH_LO_T) n_cmd = 2'b00;
                            end else begin
                                n_cmd = 2'b00;
                            end
                            if (n_tok_cnt < 5'd31) n_tok_cnt = n_tok_cnt + 5'd1;
                        end
                    end
                end
                PH_KEY_SKIP, PH_KEY: begin
                    go = 1'b1;
                    if (n_phase == PH_KEY_SKIP) begin
                        if (is_sp) begin
                            go = 1'b0;
                        end else if (is_dl) begin
                            go = 1'b0;
                            n_phase = PH_DRAIN;
                            n_outcome = OUTC_FAIL;
                        end else begin
                            n_key_cnt = '0;
                            n_phase = PH_KEY;
                        end
                    end
                    if (go) begin
                        if (is_dl) begin
                            if (n_cmd == 2'b10) begin
                                if (is_sp) begin
                                    n_phase = PH_FLAGS_SKIP;
                                end else begin
                                    n_phase = PH_DRAIN;
                                    n_outcome = OUTC_FAIL;
                                end
                            end else begin
                                n_phase = PH_EOL_SKIP;
                                f_eol(i_pkt_byte, n_cmd, n_vrem, n_phase, n_outcome);
                            end
                        end else if (n_key_cnt >= i_max_key_len) begin
                            n_phase = PH_DRAIN;
                            n_outcome = OUTC_FAIL;
                        end else begin
                            n_key_cnt = n_key_cnt + 8'd1;
                            has_byte = 1'b1;
                            kind_byte = KIND_KEY;
                        end
                    end
                end
                PH_FLAGS_SKIP, PH_EXP_SKIP, PH_BYTES_SKIP: begin
                    if (is_sp) begin
                        n_phase = n_phase;
                    end else if (is_dl) begin
                        n_phase = PH_DRAIN;
                        n_outcome = OUTC_FAIL;
                    end else begin
                        nc = f_num_char(i_pkt_byte, 5'd0, 33'd0, 3'd0);
                        n_tok_cnt = nc.tok;
                        n_acc = nc.acc;
                        n_marks = nc.marks;
                        if (nc.bad) begin
                            n_phase = PH_DRAIN;
                            n_outcome = OUTC_FAIL;
                        end else if (n_phase == PH_FLAGS_SKIP) begin
                            n_phase = PH_FLAGS;
                        end else if (n_phase == PH_EXP_SKIP) begin
                            n_phase = PH_EXP;
                        end else begin
                            n_phase = PH_BYTES;
                        end
                    end
                end
                PH_FLAGS, PH_EXP, PH_BYTES: begin
                    if (!is_dl) begin
                        nc = f_num_char(i_pkt_byte, n_tok_cnt, n_acc, n_marks);
                        n_tok_cnt = nc.tok;
                        n_acc = nc.acc;
                        n_marks = nc.marks;
                        if (nc.bad) begin
                            n_phase = PH_DRAIN;
                            n_outcome = OUTC_FAIL;
                        end
                    end else begin
                        num_ok = n_marks[MARK_DIGIT] && n_tok_cnt >= 5'd1 &&
                                 n_tok_cnt <= TOK_LIMIT && !n_acc[32] &&
                                 !(n_marks[MARK_MINUS] && n_acc != 33'd0);
                        if (!num_ok) begin
                            n_phase = PH_DRAIN;
                            n_outcome = OUTC_FAIL;
                        end else if (n_phase == PH_BYTES) begin
                            if (n_acc[31:0] > {11'b0, i_max_value_len}) begin
                                n_phase = PH_DRAIN;
                                n_outcome = OUTC_FAIL;
                            end else begin
                                n_vcount = n_acc[20:0];
                                n_vrem = n_acc[20:0];
                                n_phase = PH_EOL_SKIP;
                                f_eol(i_pkt_byte, n_cmd, n_vrem, n_phase, n_outcome);
                            end
                        end else begin
                            if (n_phase == PH_FLAGS) n_flags = n_acc[31:0];
                            else n_expiry = n_acc[31:0];
                            if (!is_sp) begin
                                n_phase = PH_DRAIN;
                                n_outcome = OUTC_FAIL;
                            end else if (n_phase == PH_FLAGS) begin
                                n_phase = PH_EXP_SKIP;
                            end else begin
                                n_phase = PH_BYTES_SKIP;
                            end
                        end
                    end
                end
                PH_EOL_SKIP: begin
                    f_eol(i_pkt_byte, n_cmd, n_vrem, n_phase, n_outcome);
                end
                PH_EOL_LF: begin
                    if (i_pkt_byte == CH_LF) begin
                        n_phase = PH_EOL_SKIP;
                        f_eol(i_pkt_byte, n_cmd, n_vrem, n_phase, n_outcome);
                    end else begin
                        n_phase = PH_DRAIN;
                        n_outcome = OUTC_FAIL;
                    end
                end
                PH_VALUE: begin
                    n_vrem = n_vrem - 21'd1;
                    if (n_vrem == 21'd0) n_phase = PH_VEOL;
                    has_byte = 1'b1;
                    kind_byte = KIND_VALUE;
                end
                PH_VEOL: begin
                    if (i_pkt_byte == CH_CR) begin
                        n_phase = PH_VEOL_LF;
                    end else begin
                        n_phase = PH_DRAIN;
                        n_outcome = (i_pkt_byte == CH_LF) ? OUTC_OK : OUTC_FAIL;
                    end
                end
                PH_VEOL_LF: begin
                    n_phase = PH_DRAIN;
                    n_outcome = (i_pkt_byte == CH_LF) ? OUTC_OK : OUTC_FAIL;
                end
                default: begin
                    n_phase = n_phase;
                end
            endcase
        end

        // Byte result.
        rb = '0;
        rb.kind = t_kind'(kind_byte);
        rb.data = i_pkt_byte;
        rb.end_of_run = !i_last_byte;

        // Verdict result.
        rv = '0;
        rv.kind = KIND_VERDICT;
        rv.end_of_run = 1'b1;
        if (n_outcome == OUTC_OK) begin
            rv.verdict_ok = 1'b1;
            rv.cmd_is_set = (n_cmd == 2'b10);
            rv.key_len = n_key_cnt;
            if (n_cmd == 2'b10) begin
                rv.item_flags = n_flags;
                rv.expire_time = n_expiry;
                rv.value_bytes = n_vcount;
            end
        end

        // Order the results; an idle parser ignores the byte entirely.
        o_res0 = has_byte ? rb : rv;
        o_res1 = rv;
        if (n_phase == PH_IDLE) begin
            o_push_cnt = 2'd0;
        end else begin
            o_push_cnt = {1'b0, has_byte} + {1'b0, i_last_byte};
            if (i_last_byte) n_phase = PH_IDLE;
        end
        if (!i_accept) o_push_cnt = 2'd0;
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_outcome <= OUTC_PENDING;
            r_hdr_cnt <= '0;
            r_tok_cnt <= '0;
            r_cmd     <= 2'b11;
            r_key_cnt <= '0;
            r_acc     <= '0;
            r_marks   <= '0;
            r_flags   <= '0;
            r_expiry  <= '0;
            r_vcount  <= '0;
            r_vrem    <= '0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_outcome <= n_outcome;
            r_hdr_cnt <= n_hdr_cnt;
            r_tok_cnt <= n_tok_cnt;
            r_cmd     <= n_cmd;
            r_key_cnt <= n_key_cnt;
            r_acc     <= n_acc;
            r_marks   <= n_marks;
            r_flags   <= n_flags;
            r_expiry  <= n_expiry;
            r_vcount  <= n_vcount;
            r_vrem    <= n_vrem;
        end
    end

endmodule
`default_nettype wire

/* rtl/kvp_out_queue.sv */
// Two-entry result register that holds the results of one byte until they are taken.
`default_nettype none
module kvp_out_queue
    import kvp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_result    i_res0,
    input  wire t_result    i_res1,
    input  wire logic [1:0] i_push_cnt,
    output logic            o_room,
    output logic            o_valid,
    input  wire logic       i_ready,
    output t_result         o_head
);

    t_result    r_slot0, r_slot1;
    logic [1:0] r_cnt;
    logic       pop;

    assign pop     = (r_cnt != 2'd0) && i_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign o_head  = r_slot0;
    // Room for two results after this cycle's transfer.
    assign o_room  = (r_cnt == 2'd0) || (r_cnt == 2'd1 && pop);

    // Occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_push_cnt != 2'd0) begin
            r_cnt <= i_push_cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // Result slots; a push only comes when the queue is empty or empties this cycle.
    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_slot0 <= i_res0;
            r_slot1 <= i_res1;
        end else if (pop) begin
            r_slot0 <= r_slot1;
        end
    end

endmodule
`default_nettype wire

/* rtl/kv_text_request_parser_core.sv */
// Top level of the text request parser: configuration registers, parser and result queue.
//
// The input channel takes one payload byte per transfer with first and last
// marks; protocol and port are sampled on the first byte. Each byte is parsed
// in the cycle it is accepted and its results (a header, key or value byte,
// and at the end of the packet a verdict) are written to a two-entry result
// register, so a result appears on the output channel in the cycle after its
// byte. The block takes one byte per cycle while each byte yields at most one
// result and the receiver is ready; the result register drains one result per
// cycle, so a last byte with a byte result and a verdict delays the next byte.
// When the receiver stalls, the result register fills and the input ready
// drops until there is room for the results of one more byte.
// Reset puts the parser idle, empties the result register and loads the
// configuration registers with their defaults. Configuration is written
// over the APB port in a setup and an access phase; pready stays high.
`default_nettype none
module kv_text_request_parser_core
    import kvp_pkg::*;
#(
    parameter int HEADER_BYTES     = 8,
    parameter int NUMBER_TOKEN_MAX = 15
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    kvp_in_if.sink           in_ch,
    kvp_out_if.source        out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [15:0] r_listen_port;
    logic [7:0]  r_max_key_len;
    logic [20:0] r_max_value_len;
    logic        accept;
    logic        room;
    t_result     res0, res1, head;
    logic [1:0]  push_cnt;

    assign pready = 1'b1;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_listen_port   <= 16'd11211;
            r_max_key_len   <= 8'd250;
            r_max_value_len <= 21'd1024;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_LISTEN_PORT:   r_listen_port   <= pwdata[15:0];
                REG_MAX_KEY_LEN:   r_max_key_len   <= pwdata[7:0];
                REG_MAX_VALUE_LEN: r_max_value_len <= pwdata[20:0];
                default:           r_listen_port   <= r_listen_port;
            endcase
        end
    end

    // Register read back.
    always_comb begin
        unique case (paddr[3:2])
            REG_LISTEN_PORT:   prdata = {16'b0, r_listen_port};
            REG_MAX_KEY_LEN:   prdata = {24'b0, r_max_key_len};
            REG_MAX_VALUE_LEN: prdata = {11'b0, r_max_value_len};
            default:           prdata = 32'b0;
        endcase
    end

    assign in_ch.ready = room;
    assign accept      = in_ch.valid && room;

    kvp_parser #(
        .HEADER_BYTES     (HEADER_BYTES),
        .NUMBER_TOKEN_MAX (NUMBER_TOKEN_MAX)
    ) u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_pkt_byte      (in_ch.pkt_byte),
        .i_first_byte    (in_ch.first_byte),
        .i_last_byte     (in_ch.last_byte),
        .i_is_udp        (in_ch.is_udp),
        .i_dst_port      (in_ch.dst_port),
        .i_listen_port   (r_listen_port),
        .i_max_key_len   (r_max_key_len),
        .i_max_value_len (r_max_value_len),
        .o_res0          (res0),
        .o_res1          (res1),
        .o_push_cnt      (push_cnt)
    );

    kvp_out_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_res0     (res0),
        .i_res1     (res1),
        .i_push_cnt (push_cnt),
        .o_room     (room),
        .o_valid    (out_ch.valid),
        .i_ready    (out_ch.ready),
        .o_head     (head)
    );

    // Result payload.
    assign out_ch.out_kind    = head.kind;
    assign out_ch.out_byte    = head.data;
    assign out_ch.verdict_ok  = head.verdict_ok;
    assign out_ch.cmd_is_set  = head.cmd_is_set;
    assign out_ch.key_len     = head.key_len;
    assign out_ch.item_flags  = head.item_flags;
    assign out_ch.expire_time = head.expire_time;
    assign out_ch.value_bytes = head.value_bytes;
    assign out_ch.end_of_run  = head.end_of_run;

endmodule
`default_nettype wire
